@@ sv/assert_macros.svh @@
// Assertion macros used by the gzip header checker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold on every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

@@ sv/gzhc_pkg.sv @@
// Types and constants shared by the gzip header checker modules.
package gzhc_pkg;

   // Verdict codes; too short wins, else the first failing check wins
   typedef enum logic [3:0] {
      ST_OK    = 4'd0,
      ST_SHORT = 4'd1,
      ST_ID1   = 4'd2,
      ST_ID2   = 4'd3,
      ST_CM    = 4'd4,
      ST_FLG   = 4'd5,
      ST_XFL   = 4'd6,
      ST_OS    = 4'd7,
      ST_NAME  = 4'd8
   } status_type;

   // Fixed header layout
   localparam logic [3:0] HDR_LEN  = 4'd10;
   localparam logic [7:0] ID1_BYTE = 8'h1f;
   localparam logic [7:0] ID2_BYTE = 8'h8b;
   localparam logic [7:0] CM_BYTE  = 8'h08;
   localparam logic [7:0] FLG_BYTE = 8'h08;
   localparam logic [7:0] XFL_BYTE = 8'h02;
   localparam logic [7:0] OS_BYTE  = 8'h03;

   // One accepted stream byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_item_type;

   // One verdict
   typedef struct packed {
      status_type  status_code;
      logic        header_valid;
      logic [31:0] mod_time;
      logic [7:0]  name_length;
   } verdict_type;

endpackage

@@ sv/gzhc_in_stage.sv @@
// Input register stage of the gzip header checker.
module gzhc_in_stage
   import gzhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        advance,
   output logic        item_valid,
   output in_item_type item
);

   logic        vld_ff, vld_in;
   in_item_type item_ff;
   logic        accept;

   // Take a new transaction when empty or when the held one moves on
   assign req_tready = !vld_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte <= req_tdata;
         item_ff.last_byte <= req_tlast;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

@@ sv/gzhc_hdr_track.sv @@
// Per-stream header tracking and verdict logic of the gzip header checker.
module gzhc_hdr_track
   import gzhc_pkg::*;
#(
   parameter logic [7:0] NAME_CAP = 8'd255
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  in_item_type item,
   output verdict_type verdict
);

   logic [3:0]  pos_ff, pos_in, pos_upd;
   status_type  err_ff, err_in, err_upd, byte_err, status;
   logic [31:0] time_ff, time_in, time_upd;
   logic [7:0]  cnt_ff, cnt_in, cnt_upd;
   logic        end_ff, end_in, end_upd;
   logic [7:0]  b;

   assign b = item.data_byte;

   // Header checks, mtime capture and name counting for one byte
   always_comb begin
      byte_err = ST_OK;
      pos_upd  = pos_ff;
      time_upd = time_ff;
      cnt_upd  = cnt_ff;
      end_upd  = end_ff;
      if (pos_ff < HDR_LEN) begin
         case (pos_ff)
            4'd0: if (b != ID1_BYTE) byte_err = ST_ID1;
            4'd1: if (b != ID2_BYTE) byte_err = ST_ID2;
            4'd2: if (b != CM_BYTE)  byte_err = ST_CM;
            4'd3: if (b != FLG_BYTE) byte_err = ST_FLG;
            4'd4: time_upd[7:0]   = b;
            4'd5: time_upd[15:8]  = b;
            4'd6: time_upd[23:16] = b;
            4'd7: time_upd[31:24] = b;
            4'd8: if (b != XFL_BYTE) byte_err = ST_XFL;
            4'd9: if (b != OS_BYTE)  byte_err = ST_OS;
            default: byte_err = ST_OK;
         endcase
         pos_upd = pos_ff + 4'd1;
      end else if (!end_ff) begin
         if (b == 8'd0 || cnt_ff >= NAME_CAP) begin
            end_upd = 1'b1;
         end else begin
            cnt_upd = cnt_ff + 8'd1;
            end_upd = (cnt_upd >= NAME_CAP);
         end
      end
      err_upd = (err_ff == ST_OK && byte_err != ST_OK) ? byte_err : err_ff;
   end

   // Verdict for a final byte
   always_comb begin
      if (pos_ff < (HDR_LEN - 4'd1)) begin
         status = ST_SHORT;
      end else if (err_upd != ST_OK) begin
         status = err_upd;
      end else if (cnt_upd == 8'd0) begin
         status = ST_NAME;
      end else begin
         status = ST_OK;
      end
      verdict.status_code  = status;
      verdict.header_valid = (status == ST_OK);
      verdict.mod_time     = (status == ST_OK || status == ST_XFL || status == ST_OS ||
                              status == ST_NAME) ? time_upd : 32'd0;
      verdict.name_length  = (status == ST_OK) ? cnt_upd : 8'd0;
   end

   // Next state: final byte restarts tracking for the next stream
   always_comb begin
      pos_in  = pos_ff;
      err_in  = err_ff;
      time_in = time_ff;
      cnt_in  = cnt_ff;
      end_in  = end_ff;
      if (item_valid) begin
         if (item.last_byte) begin
            pos_in  = 4'd0;
            err_in  = ST_OK;
            time_in = 32'd0;
            cnt_in  = 8'd0;
            end_in  = 1'b0;
         end else begin
            pos_in  = pos_upd;
            err_in  = err_upd;
            time_in = time_upd;
            cnt_in  = cnt_upd;
            end_in  = end_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd0;
         err_ff  <= ST_OK;
         time_ff <= 32'd0;
         cnt_ff  <= 8'd0;
         end_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         err_ff  <= err_in;
         time_ff <= time_in;
         cnt_ff  <= cnt_in;
         end_ff  <= end_in;
      end
   end

endmodule

@@ sv/gzip_header_checker_unit.sv @@
// Top level of the gzip header checker.
//
// A gzip stream enters on the req_ channel, one byte per transaction, with
// req_tlast high on the final byte. The final byte produces one verdict
// transaction on the rsp_ channel; other bytes produce nothing. The verdict
// carries a status code (first failing check, too short wins), a header
// valid flag, the little-endian mtime and the file-name length, capped at
// MAX_NAME (in effect at most 255).
// The final byte is registered in the input register, then the result
// register takes its verdict and raises rsp_tvalid. Throughput: one byte
// per cycle, unless a final byte waits on a busy result register; the
// compare and count update between the two registers are combinational.
// Reset clears the stream position, error and counters and empties both
// registers. When the receiver stalls, the verdict holds in the result
// register; non-final bytes still flow, and a second final byte waits in
// the input register until the result register frees up.
`include "assert_macros.svh"

module gzip_header_checker_unit
   import gzhc_pkg::*;
#(
   parameter int unsigned MAX_NAME = 255
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [3:0] status_code, [4] header_valid,
                                    // [36:5] mod_time, [44:37] name_length,
                                    // [47:45] zero
);

   localparam logic [7:0] NAME_CAP = (MAX_NAME > 255) ? 8'd255 : MAX_NAME[7:0];

   logic        item_valid, advance, out_free;
   in_item_type item;
   verdict_type verdict;
   logic        rsp_vld_ff, rsp_vld_in;
   verdict_type rsp_data_ff;

   gzhc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   gzhc_hdr_track #(
      .NAME_CAP (NAME_CAP)
   ) u_hdr_track (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (item),
      .verdict    (verdict)
   );

   // A held byte moves on unless it is final and the result slot is busy
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign advance  = item_valid && (!item.last_byte || out_free);

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && item.last_byte) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance && item.last_byte) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.name_length, rsp_data_ff.mod_time,
                        rsp_data_ff.header_valid, rsp_data_ff.status_code};

   // Verdict consistency checks
   `CHK_IMPLY(a_valid_flag, clock, reset, rsp_vld_ff,
      rsp_data_ff.header_valid == (rsp_data_ff.status_code == ST_OK),
      "header_valid disagrees with status")
   `CHK_IMPLY(a_mtime_zero, clock, reset,
      rsp_vld_ff && (rsp_data_ff.status_code == ST_SHORT ||
      rsp_data_ff.status_code == ST_ID1 || rsp_data_ff.status_code == ST_ID2 ||
      rsp_data_ff.status_code == ST_CM || rsp_data_ff.status_code == ST_FLG),
      rsp_data_ff.mod_time == 32'd0, "mtime reported before FLG check passed")
   `CHK_IMPLY(a_name_zero, clock, reset,
      rsp_vld_ff && rsp_data_ff.status_code != ST_OK,
      rsp_data_ff.name_length == 8'd0, "name length on failed header")
   `CHK_IMPLY(a_name_range, clock, reset,
      rsp_vld_ff && rsp_data_ff.status_code == ST_OK,
      rsp_data_ff.name_length != 8'd0 && rsp_data_ff.name_length <= NAME_CAP,
      "name length out of range on good header")

endmodule

@@ tb/sv/tb_gzip_header_checker_unit.sv @@
// Self-checking testbench for gzip_header_checker_unit: byte streams in, one verdict per stream.
module tb_gzip_header_checker_unit;
   import gzhc_pkg::*;

   localparam int unsigned MAX_NAME = 255;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MIN_BYTES    = 500;
   localparam int RND_STREAMS  = 6;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 8;

   // Tracks one stream at a time and predicts the verdict of its final byte
   class gzip_verdict_board;
      int unsigned name_cap;
      int          byte_pos;
      status_type  first_err;
      logic [31:0] mtime_acc;
      logic [7:0]  name_cnt;
      bit          name_done;
      verdict_type pending_verdicts[$];
      int          mismatches;
      int          verdicts_checked;
      int          streams_noted;
      int          status_hits[9];

      function new(int unsigned max_name);
         name_cap = (max_name > 255) ? 255 : max_name;
         clear_stream();
      endfunction

      function void clear_stream();
         byte_pos  = 0;
         first_err = ST_OK;
         mtime_acc = '0;
         name_cnt  = '0;
         name_done = 1'b0;
      endfunction

      // Accepted input transaction: update the stream state, queue a verdict on last
      function void note_byte(logic [7:0] b, bit last);
         status_type  err;
         int          pos;
         verdict_type v;
         pos = byte_pos;
         err = ST_OK;
         if (pos < HDR_LEN) begin
            case (pos)
               0: if (b != ID1_BYTE) err = ST_ID1;
               1: if (b != ID2_BYTE) err = ST_ID2;
               2: if (b != CM_BYTE) err = ST_CM;
               3: if (b != FLG_BYTE) err = ST_FLG;
               8: if (b != XFL_BYTE) err = ST_XFL;
               9: if (b != OS_BYTE) err = ST_OS;
               default: mtime_acc[8*(pos-4) +: 8] = b;
            endcase
            if (first_err == ST_OK && err != ST_OK) first_err = err;
            byte_pos = pos + 1;
         end else if (!name_done) begin
            if (b == 8'h00 || name_cnt >= name_cap) begin
               name_done = 1'b1;
            end else begin
               name_cnt++;
               if (name_cnt >= name_cap) name_done = 1'b1;
            end
         end
         if (!last) return;

         // too short beats every header check
         if (pos + 1 < HDR_LEN) v.status_code = ST_SHORT;
         else if (first_err != ST_OK) v.status_code = first_err;
         else if (name_cnt == 0) v.status_code = ST_NAME;
         else v.status_code = ST_OK;
         v.header_valid = (v.status_code == ST_OK);
         v.mod_time = (v.status_code == ST_OK || v.status_code == ST_XFL ||
                       v.status_code == ST_OS || v.status_code == ST_NAME) ? mtime_acc : '0;
         v.name_length = (v.status_code == ST_OK) ? name_cnt : '0;
         pending_verdicts.push_back(v);
         streams_noted++;
         status_hits[v.status_code]++;
         clear_stream();
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      // Accepted result transaction against the oldest expectation
      task check_verdict(logic [47:0] d);
         verdict_type exp;
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict with none pending, tdata %h", d));
            return;
         end
         exp = pending_verdicts.pop_front();
         verdicts_checked++;
         if (d[3:0] != exp.status_code)
            report_mismatch($sformatf("verdict %0d: status %0d, expected %0d",
                                      verdicts_checked, d[3:0], exp.status_code));
         if (d[4] != exp.header_valid)
            report_mismatch($sformatf("verdict %0d: header_valid %0b, expected %0b",
                                      verdicts_checked, d[4], exp.header_valid));
         if (d[36:5] != exp.mod_time)
            report_mismatch($sformatf("verdict %0d: mod_time %h, expected %h",
                                      verdicts_checked, d[36:5], exp.mod_time));
         if (d[44:37] != exp.name_length)
            report_mismatch($sformatf("verdict %0d: name_length %0d, expected %0d",
                                      verdicts_checked, d[44:37], exp.name_length));
         if (d[47:45] != 3'b000)
            report_mismatch($sformatf("verdict %0d: pad bits %b not zero",
                                      verdicts_checked, d[47:45]));
      endtask

      task check_done();
         if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [3:0] status_code, [4] header_valid, [36:5] mod_time,
                             // [44:37] name_length, [47:45] zero

   gzip_verdict_board board = new(MAX_NAME);
   bit          calm;
   int          bytes_sent;
   int          cycles;
   logic [7:0]  s[$];
   int          bad_idx[6] = '{0, 1, 2, 3, 8, 9};

   gzip_header_checker_unit #(.MAX_NAME(MAX_NAME)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: sample at the edge, then pick the next ready value
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_verdict(rsp_tdata);
         rsp_tready <= calm || ($urandom_range(99) >= 31);
      end
   end

   // Fixed header with the given mtime, little-endian
   function automatic void add_header(ref logic [7:0] q[$], input logic [31:0] mt);
      q.push_back(ID1_BYTE);
      q.push_back(ID2_BYTE);
      q.push_back(CM_BYTE);
      q.push_back(FLG_BYTE);
      for (int i = 0; i < 4; i++) q.push_back(mt[8*i +: 8]);
      q.push_back(XFL_BYTE);
      q.push_back(OS_BYTE);
   endfunction

   // Name bytes; fill of zero means random non-NUL content
   function automatic void add_name(ref logic [7:0] q[$], input int n, input logic [7:0] fill);
      for (int i = 0; i < n; i++)
         q.push_back((fill == 8'h00) ? 8'($urandom_range(255, 1)) : fill);
   endfunction

   function automatic void trim(ref logic [7:0] q[$], input int len);
      while (q.size() > len) void'(q.pop_back());
   endfunction

   // One input transaction, with random idle cycles ahead of it
   task automatic push_byte(input logic [7:0] b, input bit last);
      while (!calm && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_stream(input logic [7:0] q[$]);
      for (int i = 0; i < q.size(); i++) push_byte(q[i], i == q.size() - 1);
   endtask

   initial begin : stimulus
      int         kind;
      int         n;
      int         len;
      int         pick;
      int         rnd_stream;
      int         waited;
      string      hits;
      status_type st;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      calm = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // clean header, one-byte name ended by NUL
      s = {}; add_header(s, 32'h0000_0000); add_name(s, 1, 8'h61); s.push_back(8'h00);
      send_stream(s);
      // all-ones mtime, name ended by the stream end
      s = {}; add_header(s, 32'hffff_ffff); add_name(s, 3, 8'hff); send_stream(s);
      // bytes after the NUL are ignored
      s = {}; add_header(s, 32'h1234_5678); add_name(s, 2, 8'h01); s.push_back(8'h00);
      s.push_back(8'hff); s.push_back(8'h41); s.push_back(8'h00); send_stream(s);
      // header only, then header plus bare NUL: name missing
      s = {}; add_header(s, 32'hdead_beef); send_stream(s);
      s = {}; add_header(s, 32'h8000_0001); s.push_back(8'h00); send_stream(s);
      // too short with a good prefix
      foreach (bad_idx[k]) begin
         if (k < 3) begin
            s = {}; add_header(s, 32'h0102_0304); trim(s, (k == 0) ? 1 : (k == 1) ? 5 : 9);
            send_stream(s);
         end
      end
      // too short wins over a failed ID1 or FLG
      s = {8'h00}; send_stream(s);
      s = {}; add_header(s, 32'h0); s[3] = 8'h09; trim(s, 4); send_stream(s);
      // each header check failing on its own
      foreach (bad_idx[k]) begin
         s = {}; add_header(s, $urandom); s[bad_idx[k]] = s[bad_idx[k]] ^ 8'h80;
         add_name(s, 1, 8'h00); s.push_back(8'h00); send_stream(s);
      end
      // bad CM and bad OS: the earlier one is reported
      s = {}; add_header(s, 32'h0bad_0bad); s[2] = 8'h07; s[9] = 8'hff;
      add_name(s, 2, 8'h00); send_stream(s);
      // name hits the cap and the stream runs on, with no idling on either side
      calm = 1'b1;
      s = {}; add_header(s, 32'h5555_aaaa); add_name(s, 256, 8'hff); send_stream(s);
      calm = 1'b0;

      // random streams, mostly well formed
      rnd_stream = 0;
      while (bytes_sent < MIN_BYTES || rnd_stream < RND_STREAMS) begin
         kind = $urandom_range(99);
         s = {};
         if (kind < 8) begin
            len = $urandom_range(9, 1);
            add_header(s, $urandom);
            if ($urandom_range(1) == 1)
               for (int i = 0; i < s.size(); i++) s[i] = 8'($urandom);
            trim(s, len);
         end else if (kind < 13) begin
            n = $urandom_range(30, 1);
            repeat (n) s.push_back(8'($urandom));
         end else begin
            add_header(s, $urandom);
            if ($urandom_range(99) < 15) begin
               n = bad_idx[$urandom_range(5)];
               s[n] = s[n] ^ 8'($urandom_range(255, 1));
            end
            pick = $urandom_range(99);
            n = (pick < 90) ? $urandom_range(20, 0) : $urandom_range(60, 21);
            add_name(s, n, 8'h00);
            if ($urandom_range(99) < 60) begin
               s.push_back(8'h00);
               repeat ($urandom_range(5)) s.push_back(8'($urandom));
            end
         end
         send_stream(s);
         rnd_stream++;
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain outstanding verdicts, then let the pipeline settle
      waited = 0;
      while (board.pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      board.check_done();

      hits = "";
      for (int k = 0; k < 9; k++) begin
         st = status_type'(k);
         hits = {hits, $sformatf(" %s=%0d", st.name(), board.status_hits[k])};
      end
      $display("Sent %0d bytes in %0d streams, checked %0d verdicts",
               bytes_sent, board.streams_noted, board.verdicts_checked);
      $display("Verdicts by status:%s", hits);
      if (board.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
